>>> rtl/core/pdi_pkg.sv
// Shared types, widths and codes for the PID double-integral step core.
package pdi_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int GAIN_W    = 32;
  localparam int STEP_W    = 31;
  localparam int STATE_W   = 48;
  localparam int ACC_W     = 64;
  localparam int SQ_W      = 63;
  localparam int DIV_NUM_W = 80;
  localparam int DIV_DEN_W = 48;
  localparam int DIV_Q_W   = 47;
  localparam int DIV_CNT_W = 7;

  localparam logic [DIV_Q_W-1:0] Q_LIM = '1;

  // Job codes, run in this order
  localparam int JOB_W = 4;
  localparam logic [JOB_W-1:0] J_D1  = 4'd0;
  localparam logic [JOB_W-1:0] J_D2A = 4'd1;
  localparam logic [JOB_W-1:0] J_D2B = 4'd2;
  localparam logic [JOB_W-1:0] J_I1  = 4'd3;
  localparam logic [JOB_W-1:0] J_I2  = 4'd4;
  localparam logic [JOB_W-1:0] J_T0  = 4'd5;
  localparam logic [JOB_W-1:0] J_T1  = 4'd6;
  localparam logic [JOB_W-1:0] J_T2  = 4'd7;
  localparam logic [JOB_W-1:0] J_T3  = 4'd8;
  localparam logic [JOB_W-1:0] J_T4  = 4'd9;
  localparam logic [JOB_W-1:0] J_AVG = 4'd10;
  localparam logic [JOB_W-1:0] J_SQ  = 4'd11;

  // Phases within a job
  localparam logic [1:0] PH_LOAD = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_KD2  = 3'd0;
  localparam logic [2:0] REG_KD1  = 3'd1;
  localparam logic [2:0] REG_KP   = 3'd2;
  localparam logic [2:0] REG_KI   = 3'd3;
  localparam logic [2:0] REG_KI2  = 3'd4;
  localparam logic [2:0] REG_BIAS = 3'd5;
  localparam logic [2:0] REG_STEP = 3'd6;
  localparam logic [2:0] REG_AVG  = 3'd7;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kd2;
    logic signed [GAIN_W-1:0] kd1;
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] ki2;
    logic signed [GAIN_W-1:0] bias;
    logic [STEP_W-1:0]        time_step;
    logic                     avg;
  } pdi_cfg_t;

  typedef struct packed {
    logic             load;
    logic             act;
    logic [JOB_W-1:0] job;
    logic [1:0]       phase;
    logic             div_start;
  } pdi_cmd_t;

  typedef struct packed {
    logic avg_skip;
    logic div_done;
  } pdi_stat_t;

endpackage

>>> rtl/core/pdi_if.sv
// Valid/ready channel interfaces for the input and result items.
interface pdi_in_if import pdi_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       restart;
  modport source(output valid, sample, restart, input ready);
  modport sink(input valid, sample, restart, output ready);
endinterface

interface pdi_out_if import pdi_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] result;
  logic [SQ_W-1:0]            result_squared;
  modport source(output valid, result, result_squared, input ready);
  modport sink(input valid, result, result_squared, output ready);
endinterface

>>> rtl/core/pdi_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, saturated quotient.
module pdi_div import pdi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 busy,
  output logic                 done,
  output logic [DIV_Q_W-1:0]   quo
);

  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W:0]   shifted;
  logic                 ge;
  logic [DIV_DEN_W:0]   rem_nxt;

  assign shifted = {rem_r, quo_r[DIV_NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign rem_nxt = ge ? shifted - {1'b0, den_r} : shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = (|quo_r[DIV_NUM_W-1:DIV_Q_W]) ? Q_LIM : quo_r[DIV_Q_W-1:0];

endmodule

>>> rtl/core/pdi_ctrl.sv
// Job sequencer: walks the step's jobs and phases, owns the handshakes.
module pdi_ctrl import pdi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  pdi_stat_t stat,
  output pdi_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [JOB_W-1:0] job_r, job_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             is_div;
  logic             slot_free;

  assign is_div    = (job_r == J_D1) || (job_r == J_D2A) || (job_r == J_D2B) ||
                     (job_r == J_AVG);
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.job       = job_r;
    cmd.phase     = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
          job_nxt   = J_D1;
          phase_nxt = PH_LOAD;
        end
      end
      S_RUN: begin
        priority if (job_r == J_AVG && phase_r == PH_LOAD && stat.avg_skip) begin
          // no averaging this step
          job_nxt = J_SQ;
        end else if (job_r == J_SQ && phase_r == PH_DONE) begin
          if (slot_free) begin
            cmd.act       = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.act = 1'b1;
          unique case (phase_r)
            PH_LOAD: phase_nxt = PH_MUL;
            PH_MUL: begin
              if (is_div) begin
                cmd.div_start = 1'b1;
                state_nxt     = S_DIV;
              end else begin
                phase_nxt = PH_LOW;
              end
            end
            PH_LOW: phase_nxt = PH_DONE;
            PH_DONE: begin
              job_nxt   = job_r + 1'b1;
              phase_nxt = PH_LOAD;
            end
          endcase
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_RUN;
          phase_nxt = PH_DONE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      job_r       <= J_D1;
      phase_r     <= PH_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/pdi_datapath.sv
// Step state, shared 32x32 multiplier, operand selection and result registers.
module pdi_datapath import pdi_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pdi_cmd_t                   cmd,
  input  pdi_cfg_t                   cfg,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_restart,
  input  logic [DIV_Q_W-1:0]         div_quo,
  output logic [DIV_NUM_W-1:0]       div_num,
  output logic [DIV_DEN_W-1:0]       div_den,
  output logic                       avg_skip,
  output logic signed [SAMPLE_W-1:0] out_result,
  output logic [SQ_W-1:0]            out_result_squared
);

  localparam logic signed [ACC_W-1:0] LIM48    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] TERM_LIM = 64'sh07FF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] R_MAX    = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] R_MIN    = -64'sh0000_0000_8000_0000;

  function automatic logic signed [STATE_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > LIM48) c = LIM48;
    if (v < -LIM48) c = -LIM48;
    return c[STATE_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] clamp_term(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > TERM_LIM) c = TERM_LIM;
    if (v < -TERM_LIM) c = -TERM_LIM;
    return c;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > R_MAX) c = R_MAX;
    if (v < R_MIN) c = R_MIN;
    return c[SAMPLE_W-1:0];
  endfunction

  // step state
  logic                       first_r;
  logic signed [SAMPLE_W-1:0] u1_r, u2_r;
  logic signed [STATE_W-1:0]  i1_r, i2_r, et_r;
  // per-item working registers
  logic signed [SAMPLE_W-1:0] u_r;
  logic [STEP_W-1:0]          t_r;
  logic signed [STATE_W-1:0]  d1_r, d2_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic [STATE_W-1:0]         ma_r;
  logic [GAIN_W-1:0]          mb_r;
  logic                       neg_r;
  logic [ACC_W-1:0]           prod_r, ph_r;
  logic signed [SAMPLE_W-1:0] res_r;
  logic [DIV_NUM_W-1:0]       num_r;
  logic [DIV_DEN_W-1:0]       den_r;
  logic signed [SAMPLE_W-1:0] out_result_r;
  logic [SQ_W-1:0]            out_sq_r;

  logic signed [STATE_W-1:0]  a_sel;
  logic signed [GAIN_W:0]     b_sel;
  logic signed [ACC_W-1:0]    num_sel;
  logic [DIV_DEN_W-1:0]       den_sel;
  logic [STATE_W-1:0]         a_mag;
  logic [GAIN_W:0]            b_mag;
  logic [ACC_W-1:0]           num_mag;
  logic [SAMPLE_W-1:0]        res_mag;
  logic [GAIN_W-1:0]          mul_a, mul_b;
  logic [ACC_W-1:0]           mul_p;
  logic [ACC_W-1:0]           p_sum;
  logic signed [ACC_W-1:0]    mq;
  logic signed [STATE_W-1:0]  dq;
  logic                       is_div;
  logic                       go;

  assign is_div = (cmd.job == J_D1) || (cmd.job == J_D2A) || (cmd.job == J_D2B) ||
                  (cmd.job == J_AVG);
  assign go     = cmd.act;

  always_comb begin
    a_sel   = '0;
    b_sel   = '0;
    num_sel = '0;
    den_sel = {{(DIV_DEN_W-STEP_W){1'b0}}, t_r};
    unique case (cmd.job)
      J_D1:  num_sel = ACC_W'(u_r) - ACC_W'(u1_r);
      J_D2A: num_sel = ACC_W'(u_r) - (ACC_W'(u1_r) <<< 1) + ACC_W'(u2_r);
      J_D2B: num_sel = ACC_W'(d2_r);
      J_I1: begin
        a_sel = STATE_W'(u_r);
        b_sel = $signed({2'b00, t_r});
      end
      J_I2: begin
        a_sel = i1_r;
        b_sel = $signed({2'b00, t_r});
      end
      J_T0: begin
        a_sel = d2_r;
        b_sel = (GAIN_W+1)'(cfg.kd2);
      end
      J_T1: begin
        a_sel = d1_r;
        b_sel = (GAIN_W+1)'(cfg.kd1);
      end
      J_T2: begin
        a_sel = STATE_W'(u_r);
        b_sel = (GAIN_W+1)'(cfg.kp);
      end
      J_T3: begin
        a_sel = i1_r;
        b_sel = (GAIN_W+1)'(cfg.ki);
      end
      J_T4: begin
        a_sel = i2_r;
        b_sel = (GAIN_W+1)'(cfg.ki2);
      end
      J_AVG: begin
        num_sel = acc_r;
        den_sel = et_r;
      end
      default: ;
    endcase
  end

  assign a_mag   = a_sel[STATE_W-1] ? STATE_W'(-a_sel) : a_sel;
  assign b_mag   = b_sel[GAIN_W] ? (GAIN_W+1)'(-b_sel) : b_sel;
  assign num_mag = num_sel[ACC_W-1] ? ACC_W'(-num_sel) : num_sel;
  assign res_mag = res_r[SAMPLE_W-1] ? SAMPLE_W'(-res_r) : res_r;

  always_comb begin
    if (cmd.job == J_SQ) begin
      mul_a = res_mag;
      mul_b = res_mag;
    end else if (cmd.phase == PH_LOW) begin
      mul_a = {16'b0, ma_r[15:0]};
      mul_b = mb_r;
    end else begin
      mul_a = ma_r[STATE_W-1:16];
      mul_b = mb_r;
    end
  end

  assign mul_p = mul_a * mul_b;
  assign p_sum = ph_r + {16'b0, prod_r[ACC_W-1:16]};
  assign mq    = neg_r ? -$signed(p_sum) : $signed(p_sum);
  assign dq    = neg_r ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      u1_r    <= '0;
      u2_r    <= '0;
      i1_r    <= '0;
      i2_r    <= '0;
      et_r    <= '0;
    end else begin
      if (cmd.load) begin
        first_r <= 1'b0;
        if (in_restart) begin
          i1_r <= '0;
          i2_r <= '0;
          et_r <= '0;
        end
        // reload history on the first step after reset or after a restart
        if (in_restart || first_r) begin
          u1_r <= in_sample;
          u2_r <= in_sample;
        end
      end
      if (go && cmd.phase == PH_DONE) begin
        unique case (cmd.job)
          J_I1: i1_r <= sat48(ACC_W'(i1_r) + mq);
          J_I2: i2_r <= sat48(ACC_W'(i2_r) + mq);
          J_SQ: begin
            u2_r <= u1_r;
            u1_r <= u_r;
            et_r <= sat48(ACC_W'(et_r) + $signed(ACC_W'(t_r)));
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u_r <= in_sample;
      t_r <= (cfg.time_step == '0) ? STEP_W'(1) : cfg.time_step;
    end
    if (go) begin
      unique case (cmd.phase)
        PH_LOAD: begin
          priority if (is_div) begin
            num_r <= {num_mag, 16'b0};
            den_r <= den_sel;
            neg_r <= num_sel[ACC_W-1];
          end else if (cmd.job == J_SQ) begin
            res_r <= clamp32(acc_r);
          end else begin
            ma_r  <= a_mag;
            mb_r  <= b_mag[GAIN_W-1:0];
            neg_r <= a_sel[STATE_W-1] ^ b_sel[GAIN_W];
          end
        end
        PH_MUL: begin
          if (!is_div) prod_r <= mul_p;
        end
        PH_LOW: begin
          if (cmd.job != J_SQ) begin
            ph_r   <= prod_r;
            prod_r <= mul_p;
          end
        end
        PH_DONE: begin
          unique case (cmd.job)
            J_D1:        d1_r  <= dq;
            J_D2A, J_D2B: d2_r <= dq;
            J_T0:        acc_r <= clamp_term(mq);
            J_T1, J_T2, J_T3: acc_r <= acc_r + clamp_term(mq);
            J_T4:        acc_r <= acc_r + clamp_term(mq) + ACC_W'(cfg.bias);
            J_AVG:       acc_r <= ACC_W'(dq);
            J_SQ: begin
              out_result_r <= res_r;
              out_sq_r     <= prod_r[SQ_W-1:0];
            end
            default: ;
          endcase
        end
      endcase
    end
  end

  assign div_num            = num_r;
  assign div_den            = den_r;
  assign avg_skip           = !cfg.avg || (et_r == '0);
  assign out_result         = out_result_r;
  assign out_result_squared = out_sq_r;

endmodule

>>> rtl/core/pid_double_integral_step_core.sv
// Top level: register port, sequencer, datapath and divider of the step core.
//
//  port    dir  carries
//  in_ch   in   sample (Q16.16), restart
//  out_ch  out  result (Q16.16), result_squared (unsigned Q31.32)
//  psel..  in   register writes and reads, index at paddr[4:2]
//
// Each item runs three divides, or four with averaging on and a nonzero elapsed
// time, on the 80-step radix-2 divider. Multiplies go through one shared 32x32
// multiplier, two passes per weighted term. rst_n is synchronous: gains clear, kp
// and time_step load 1.0, history and integrals clear. A finished item waits in
// the output register while the next item is accepted and worked on.
module pid_double_integral_step_core import pdi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pdi_in_if.sink      in_ch,
  pdi_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pdi_cfg_t       cfg_r;
  pdi_cmd_t       cmd;
  pdi_stat_t      stat;
  logic [2:0]     reg_idx;
  logic           wr_en;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_Q_W-1:0]   div_quo;
  logic           div_busy;
  logic           div_done;
  logic           avg_skip;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kd2       <= '0;
      cfg_r.kd1       <= '0;
      cfg_r.kp        <= 32'sd65536;
      cfg_r.ki        <= '0;
      cfg_r.ki2       <= '0;
      cfg_r.bias      <= '0;
      cfg_r.time_step <= 31'd65536;
      cfg_r.avg       <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KD2:  cfg_r.kd2       <= pwdata;
        REG_KD1:  cfg_r.kd1       <= pwdata;
        REG_KP:   cfg_r.kp        <= pwdata;
        REG_KI:   cfg_r.ki        <= pwdata;
        REG_KI2:  cfg_r.ki2       <= pwdata;
        REG_BIAS: cfg_r.bias      <= pwdata;
        REG_STEP: cfg_r.time_step <= pwdata[STEP_W-1:0];
        REG_AVG:  cfg_r.avg       <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KD2:  prdata = cfg_r.kd2;
      REG_KD1:  prdata = cfg_r.kd1;
      REG_KP:   prdata = cfg_r.kp;
      REG_KI:   prdata = cfg_r.ki;
      REG_KI2:  prdata = cfg_r.ki2;
      REG_BIAS: prdata = cfg_r.bias;
      REG_STEP: prdata = {1'b0, cfg_r.time_step};
      REG_AVG:  prdata = {31'b0, cfg_r.avg};
    endcase
  end

  assign stat.avg_skip = avg_skip;
  assign stat.div_done = div_done;

  pdi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pdi_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg                (cfg_r),
    .in_sample          (in_ch.sample),
    .in_restart         (in_ch.restart),
    .div_quo            (div_quo),
    .div_num            (div_num),
    .div_den            (div_den),
    .avg_skip           (avg_skip),
    .out_result         (out_ch.result),
    .out_result_squared (out_ch.result_squared)
  );

  pdi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted while previous item in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result appeared without an item in work");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> !div_busy)
    else $error("divider done while still busy");

endmodule

>>> tb/pdi_tb_if.sv
// Testbench channels use the core's interfaces; nothing further is declared here.

>>> tb/pdi_checker.sv
// Step predictor and result comparator for the PID double-integral step core.
module pdi_checker import pdi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_sample,
  input  logic        in_restart,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_result,
  input  logic [62:0] out_result_squared,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending
);

  localparam longint LIM48    = 64'sh7FFF_FFFF_FFFF;
  localparam longint TERM_LIM = 64'sh07FF_FFFF_FFFF_FFFF;

  longint kd2, kd1, kp, ki, ki2, bias_r, avg_r;
  longint step_r;
  longint u1, u2, int1, int2, elapsed;
  bit     first_step;

  logic [31:0] exp_result[$];
  logic [62:0] exp_square[$];

  assign pending = exp_result.size();

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // a * b / 2^16 truncated toward zero
  function automatic longint fix_mul(longint a, longint b);
    longint unsigned ma, mb, p;
    ma = mag(a);
    mb = mag(b);
    p = (ma >> 16) * mb + (((ma & 64'hFFFF) * mb) >> 16);
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  // a * 2^16 / den truncated toward zero, saturated to 48 bits
  function automatic longint fix_div(longint a, longint unsigned den);
    longint unsigned q;
    longint r;
    q = (mag(a) << 16) / den;
    r = (q > LIM48) ? LIM48 : longint'(q);
    return a < 0 ? -r : r;
  endfunction

  task automatic predict_step(logic [31:0] smp, logic rst_hist);
    longint u, t, d1, d2, v, r, a;
    longint unsigned m, c, q, rem;
    u = longint'($signed(smp));
    t = (step_r == 0) ? 1 : step_r;
    if (rst_hist) begin
      int1 = 0; int2 = 0; elapsed = 0; first_step = 1;
    end
    if (first_step) begin
      u1 = u; u2 = u; first_step = 0;
    end
    d1 = fix_div(u - u1, t);
    d2 = fix_div(fix_div(u - 2 * u1 + u2, t), t);
    int1 = clamp_sym(int1 + fix_mul(u, t), LIM48);
    int2 = clamp_sym(int2 + fix_mul(int1, t), LIM48);
    v = clamp_sym(fix_mul(d2, kd2), TERM_LIM) + clamp_sym(fix_mul(d1, kd1), TERM_LIM)
      + clamp_sym(fix_mul(u, kp), TERM_LIM) + clamp_sym(fix_mul(int1, ki), TERM_LIM)
      + clamp_sym(fix_mul(int2, ki2), TERM_LIM) + bias_r;
    if (avg_r != 0 && elapsed > 0) begin
      m = mag(v);
      c = elapsed;
      q = m / c;
      rem = m % c;
      if (q >= 64'h8000_0000) a = LIM48;
      else a = longint'((q << 16) + ((rem << 16) / c));
      v = v < 0 ? -a : a;
    end
    r = v;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    u2 = u1;
    u1 = u;
    elapsed = clamp_sym(elapsed + t, LIM48);
    exp_result.push_back(r[31:0]);
    exp_square.push_back(63'(mag(r) * mag(r)));
  endtask

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      kd2 = 0; kd1 = 0; kp = 65536; ki = 0; ki2 = 0; bias_r = 0;
      step_r = 65536; avg_r = 0;
      u1 = 0; u2 = 0; int1 = 0; int2 = 0; elapsed = 0; first_step = 1;
      fail_count = 0;
      exp_result.delete();
      exp_square.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (cfg_paddr[4:2])
          REG_KD2:  kd2 = longint'($signed(cfg_pwdata));
          REG_KD1:  kd1 = longint'($signed(cfg_pwdata));
          REG_KP:   kp = longint'($signed(cfg_pwdata));
          REG_KI:   ki = longint'($signed(cfg_pwdata));
          REG_KI2:  ki2 = longint'($signed(cfg_pwdata));
          REG_BIAS: bias_r = longint'($signed(cfg_pwdata));
          REG_STEP: step_r = longint'(cfg_pwdata[30:0]);
          REG_AVG:  avg_r = longint'(cfg_pwdata[0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_step(in_sample, in_restart);
      if (out_valid && out_ready) begin
        if (exp_result.size() == 0) begin
          report_mismatch($sformatf("unexpected item result=%h", out_result));
        end else begin
          if (out_result !== exp_result[0])
            report_mismatch($sformatf("result got %h want %h", out_result, exp_result[0]));
          if (out_result_squared !== exp_square[0])
            report_mismatch($sformatf("result_squared got %h want %h",
                                      out_result_squared, exp_square[0]));
          void'(exp_result.pop_front());
          void'(exp_square.pop_front());
        end
      end
    end
  end

endmodule

>>> tb/tb_top.sv
// Stimulus, idling phases and verdict for the PID double-integral step core.
module tb_top import pdi_pkg::*; ;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending;
  int          send_idle_pct, recv_stall_pct;

  pdi_in_if  in_ch();
  pdi_out_if out_ch();

  pid_double_integral_step_core u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite), .paddr(cfg_paddr),
    .pwdata(cfg_pwdata), .prdata(cfg_prdata), .pready(cfg_pready)
  );

  pdi_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_sample(in_ch.sample),
    .in_restart(in_ch.restart),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_result(out_ch.result),
    .out_result_squared(out_ch.result_squared),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays up after the accepting edge until the next call or drain
  task automatic send_item(logic [31:0] smp, logic rs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1; in_ch.sample <= smp; in_ch.restart <= rs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // drop valid, wait for all results, then let the block settle
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      default: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      default: return 32'($signed($urandom_range(4 << 16)) - (2 << 16));
    endcase
  endfunction

  task automatic random_config(logic [31:0] step);
    reg_write(REG_KD2, rand_gain());
    reg_write(REG_KD1, rand_gain());
    reg_write(REG_KP, rand_gain());
    reg_write(REG_KI, rand_gain());
    reg_write(REG_KI2, rand_gain());
    reg_write(REG_BIAS, rand_gain());
    reg_write(REG_STEP, step);
    reg_write(REG_AVG, 32'($urandom_range(1)));
  endtask

  initial begin
    logic [31:0] steps[6];
    rst_n = 1'b0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    in_ch.valid = 0; in_ch.sample = '0; in_ch.restart = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults, field extremes, restart
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    send_item(32'h0001_0000, 1'b0);
    drain();
    // large gains, zero step, averaging: derivative and term saturation
    reg_write(REG_KD2, 32'h7FFF_FFFF);
    reg_write(REG_KD1, 32'h8000_0000);
    reg_write(REG_KP, 32'h7FFF_FFFF);
    reg_write(REG_KI, 32'h8000_0000);
    reg_write(REG_KI2, 32'h7FFF_FFFF);
    reg_write(REG_BIAS, 32'h8000_0000);
    reg_write(REG_STEP, 32'h0000_0000);
    reg_write(REG_AVG, 32'h1);
    send_item(32'h7FFF_FFFF, 1'b1);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h5555_5555, 1'b0);
    drain();
    // largest step: integrals saturate, averaging overflow
    reg_write(REG_STEP, 32'h7FFF_FFFF);
    reg_write(REG_AVG, 32'h0);
    for (int i = 0; i < 6; i++) send_item(i[0] ? 32'h7FFF_FFFF : 32'hAAAA_AAAA, 1'b0);
    drain();
    reg_write(REG_AVG, 32'h1);
    for (int i = 0; i < 4; i++) send_item(32'h7FFF_FFFF, 1'b0);
    drain();

    steps = '{32'h0001_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_4000,
              32'h0000_0000, 32'h0004_0000};
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      random_config(ph < 6 ? steps[ph] : (ph[0] ? $urandom : 32'($urandom_range(1 << 18))));
      for (int i = 0; i < 50; i++) send_item(rand_sample(), $urandom_range(15) == 0);
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/pdi_pkg.sv
rtl/core/pdi_if.sv
rtl/core/pdi_div.sv
rtl/core/pdi_ctrl.sv
rtl/core/pdi_datapath.sv
rtl/core/pid_double_integral_step_core.sv
tb/pdi_tb_if.sv
tb/pdi_checker.sv
tb/tb_top.sv
